### design/dslp_pkg.sv
// Package for the debounced short/long press block.
// Holds the counter width, register indexes, reset values and press codes.
// No dependencies.
`timescale 1ns / 1ps

package dslp_pkg;

    localparam int CNT_W = 16;
    localparam int IDX_W = 2;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [IDX_W-1:0] reg_idx_t;
    typedef logic [1:0]       press_event_t;

    localparam cnt_t CNT_MAX = {CNT_W{1'b1}};

    localparam reg_idx_t REG_DEBOUNCE   = 2'd0;
    localparam reg_idx_t REG_LONG_PRESS = 2'd1;
    localparam reg_idx_t REG_BUZZER     = 2'd2;

    localparam cnt_t DEBOUNCE_RST   = 16'd30;
    localparam cnt_t LONG_PRESS_RST = 16'd1500;
    localparam cnt_t BUZZER_RST     = 16'd200;

    localparam press_event_t EVT_NONE  = 2'd0;
    localparam press_event_t EVT_SHORT = 2'd1;
    localparam press_event_t EVT_LONG  = 2'd2;

    typedef struct packed {
        logic         led_on;
        logic         buzzer_on;
        press_event_t press_event;
    } result_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == CNT_MAX) ? CNT_MAX : cnt_t'(v + 1'b1);
    endfunction

endpackage

### design/debounced_short_long_press.sv
// Usage: debounced button with short/long press detection, one word per timer tick.
// s_ channel: each word is one tick carrying the sampled active-low button level.
// m_ channel: each tick yields one word: LED state, buzzer drive and press code
//   (none, short press released, long press released).
// Config port: cfg_wr_en/cfg_index/cfg_wdata write debounce, long-press and buzzer
//   lengths in ticks; write only while no word is in flight. Unknown indexes drop.
// Output: the result of an accepted tick is registered, in the output register or the skid.
// Throughput: one word per cycle while s_ready is high; the state update is three 16-bit
//   saturating counters and compares between the state registers and the output register.
// Stall: a two-entry output (register plus skid) keeps s_ready high while one
//   result waits; s_ready drops only once both entries are full.
// Reset (aresetn low, synchronous): registers return to 30/1500/200 ticks,
//   level released, counters zero, LED and buzzer off, output empty.
// Depends on dslp_pkg.
`timescale 1ns / 1ps

module debounced_short_long_press (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  dslp_pkg::reg_idx_t      cfg_index,
    input  dslp_pkg::cnt_t          cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_button_level,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_led_on,
    output logic                    m_buzzer_on,
    output dslp_pkg::press_event_t  m_press_event
);

    import dslp_pkg::*;

    cnt_t debounce_reg, long_press_reg, buzzer_reg;

    logic prev_level_reg, prev_level_next;
    cnt_t since_reg, since_next;
    logic press_reg, press_next;
    cnt_t hold_reg, hold_next;
    logic led_reg, led_next;
    logic buzz_reg, buzz_next;
    cnt_t buzz_cnt_reg, buzz_cnt_next;

    result_t res_next;
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic accept, take, deb_ok;
    press_event_t evt;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign take    = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RST;
            long_press_reg <= LONG_PRESS_RST;
            buzzer_reg     <= BUZZER_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_wdata;
                REG_LONG_PRESS: long_press_reg <= cfg_wdata;
                REG_BUZZER:     buzzer_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        prev_level_next = s_button_level;
        since_next      = (s_button_level != prev_level_reg) ? '0 : sat_inc(since_reg);
        hold_next       = press_reg ? sat_inc(hold_reg) : hold_reg;
        buzz_cnt_next   = buzz_reg ? sat_inc(buzz_cnt_reg) : buzz_cnt_reg;
        press_next      = press_reg;
        led_next        = led_reg;
        buzz_next       = buzz_reg;
        evt             = EVT_NONE;
        deb_ok          = since_next > debounce_reg;

        if (deb_ok && !press_reg && !s_button_level) begin
            press_next = 1'b1;
            hold_next  = '0;
        end
        if (deb_ok && press_reg && s_button_level) begin
            press_next = 1'b0;
            if (hold_next >= long_press_reg) begin
                buzz_next     = 1'b1;
                buzz_cnt_next = '0;
                evt           = EVT_LONG;
            end else begin
                led_next = !led_reg;
                evt      = EVT_SHORT;
            end
        end
        if (buzz_next && (buzz_cnt_next >= buzzer_reg)) begin
            buzz_next = 1'b0;
        end

        res_next.led_on      = led_next;
        res_next.buzzer_on   = buzz_next;
        res_next.press_event = evt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= 1'b1;
            since_reg      <= '0;
            press_reg      <= 1'b0;
            hold_reg       <= '0;
            led_reg        <= 1'b0;
            buzz_reg       <= 1'b0;
            buzz_cnt_reg   <= '0;
        end else if (accept) begin
            prev_level_reg <= prev_level_next;
            since_reg      <= since_next;
            press_reg      <= press_next;
            hold_reg       <= hold_next;
            led_reg        <= led_next;
            buzz_reg       <= buzz_next;
            buzz_cnt_reg   <= buzz_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || take) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_reg <= skid_reg;
            end
        end else if (accept) begin
            if (!out_valid_reg || take) begin
                out_reg <= res_next;
            end else begin
                skid_reg <= res_next;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_led_on      = out_reg.led_on;
    assign m_buzzer_on   = out_reg.buzzer_on;
    assign m_press_event = out_reg.press_event;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready && accept))
        else $error("skid filled without a stalled output");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && take) |=> (out_valid_reg && out_reg == $past(skid_reg)))
        else $error("skid word lost on drain");

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty output");
`endif

endmodule

### tb/sv/debounced_short_long_press_test.sv
// Self-checking test for debounced_short_long_press: ticks go in on s_, results come out on m_.
// A scoreboard class predicts LED, buzzer and press code per tick; plain tasks drive the ports.
// Depends on dslp_pkg and debounced_short_long_press.
`timescale 1ns / 1ps

module debounced_short_long_press_test;
    import dslp_pkg::*;

    localparam reg_idx_t REG_UNUSED = 2'd3;
    localparam int       MAX_REPORTS = 100;

    class press_scoreboard;
        cnt_t    debounce_ticks;
        cnt_t    long_ticks;
        cnt_t    buzz_ticks;
        logic    last_level;
        cnt_t    since_change;
        logic    pressed;
        cnt_t    hold_count;
        logic    led;
        logic    buzzing;
        cnt_t    buzz_count;
        result_t expected_words[$];
        int      errors;

        function new();
            debounce_ticks = 16'd30;
            long_ticks     = 16'd1500;
            buzz_ticks     = 16'd200;
            last_level     = 1'b1;
            since_change   = '0;
            pressed        = 1'b0;
            hold_count     = '0;
            led            = 1'b0;
            buzzing        = 1'b0;
            buzz_count     = '0;
            errors         = 0;
        endfunction

        function cnt_t bump(cnt_t v);
            if (&v) return v;
            return v + cnt_t'(1);
        endfunction

        function void set_reg(reg_idx_t idx, cnt_t val);
            case (idx)
                REG_DEBOUNCE:   debounce_ticks = val;
                REG_LONG_PRESS: long_ticks = val;
                REG_BUZZER:     buzz_ticks = val;
                default: ;
            endcase
        endfunction

        function void note_tick(logic level);
            result_t      word;
            press_event_t code;
            code = EVT_NONE;
            if (level != last_level) begin
                since_change = '0;
                last_level = level;
            end else begin
                since_change = bump(since_change);
            end
            if (pressed) hold_count = bump(hold_count);
            if (buzzing) buzz_count = bump(buzz_count);
            if (since_change > debounce_ticks) begin
                if (!pressed && level == 1'b0) begin
                    pressed = 1'b1;
                    hold_count = '0;
                end
                if (pressed && level == 1'b1) begin
                    pressed = 1'b0;
                    if (hold_count >= long_ticks) begin
                        buzzing = 1'b1;
                        buzz_count = '0;
                        code = EVT_LONG;
                    end else begin
                        led = ~led;
                        code = EVT_SHORT;
                    end
                end
            end
            if (buzzing && buzz_count >= buzz_ticks) buzzing = 1'b0;
            word.led_on = led;
            word.buzzer_on = buzzing;
            word.press_event = code;
            expected_words.push_back(word);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_words.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected word led=%0d buzzer=%0d event=%0d", $time,
                             got.led_on, got.buzzer_on, got.press_event);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got.led_on !== want.led_on) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: led_on expected %0d actual %0d", $time,
                             want.led_on, got.led_on);
                errors++;
            end
            if (got.buzzer_on !== want.buzzer_on) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: buzzer_on expected %0d actual %0d", $time,
                             want.buzzer_on, got.buzzer_on);
                errors++;
            end
            if (got.press_event !== want.press_event) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: press_event expected %0d actual %0d", $time,
                             want.press_event, got.press_event);
                errors++;
            end
        endfunction

        function void check_drained();
            if (expected_words.size() != 0) begin
                $display("%0t: %0d expected words never arrived", $time,
                         expected_words.size());
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    reg_idx_t     cfg_index = REG_DEBOUNCE;
    cnt_t         cfg_wdata = '0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic         s_button_level = 1'b1;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic         m_led_on;
    logic         m_buzzer_on;
    press_event_t m_press_event;

    press_scoreboard board;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int ticks_sent = 0;

    debounced_short_long_press i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_button_level (s_button_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_led_on       (m_led_on),
        .m_buzzer_on    (m_buzzer_on),
        .m_press_event  (m_press_event)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("debounced_short_long_press test failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(result_t'{m_led_on, m_buzzer_on, m_press_event});
        if (hold_request != 0) begin
            hold_left = 400;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_tick(input logic level);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_button_level <= level;
        do @(posedge aclk); while (!s_ready);
        board.note_tick(level);
        ticks_sent++;
    endtask

    task automatic send_run(input logic level, input int n);
        repeat (n) send_tick(level);
    endtask

    task automatic write_reg(input reg_idx_t idx, input cnt_t val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        board.set_reg(idx, val);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.expected_words.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic configure(input cnt_t debounce, input cnt_t long_press, input cnt_t buzzer);
        drain();
        write_reg(REG_DEBOUNCE, debounce);
        write_reg(REG_UNUSED, cnt_t'($urandom));
        write_reg(REG_LONG_PRESS, long_press);
        write_reg(REG_BUZZER, buzzer);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic bounce(input logic settle);
        repeat ($urandom_range(3)) begin
            send_run(settle, $urandom_range(1, 2));
            send_run(~settle, $urandom_range(1, 2));
        end
    endtask

    // Mostly clean presses with bounce at the edges; the rest is chatter.
    task automatic random_burst();
        int d;
        int lim_hold;
        int lim_rel;
        d = int'(board.debounce_ticks);
        lim_hold = (board.long_ticks > 40) ? 44 : int'(board.long_ticks) + 4;
        lim_rel = (board.buzz_ticks > 30) ? 30 : int'(board.buzz_ticks) + 3;
        if ($urandom_range(99) < 75) begin
            bounce(1'b1);
            send_run(1'b0, $urandom_range(d + 2, d + 2 + lim_hold));
            bounce(1'b0);
            send_run(1'b1, $urandom_range(d + 2, d + 2 + lim_rel));
        end else begin
            repeat ($urandom_range(1, 6))
                send_run(1'($urandom_range(1)), $urandom_range(1, d + 3));
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n_ticks);
        int   target;
        int   block_end;
        bit   first;
        cnt_t d;
        cnt_t l;
        cnt_t b;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        target = ticks_sent + n_ticks;
        first = 1'b1;
        while (ticks_sent < target) begin
            d = ($urandom_range(7) == 0) ? cnt_t'(0) : cnt_t'($urandom_range(1, 6));
            case ($urandom_range(9))
                0:       l = '0;
                1:       l = CNT_MAX;
                default: l = cnt_t'($urandom_range(1, 30));
            endcase
            case ($urandom_range(9))
                0:       b = '0;
                1:       b = CNT_MAX;
                default: b = cnt_t'($urandom_range(1, 25));
            endcase
            configure(d, l, b);
            if (first && send_pct == 0 && recv_pct == 0) hold_request = 1;
            first = 1'b0;
            block_end = ticks_sent + 150;
            while (ticks_sent < block_end && ticks_sent < target) random_burst();
        end
    endtask

    initial begin
        int guard;
        board = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: one short press
        send_run(1'b0, 40);
        send_run(1'b1, 40);

        // long press (zero-length buzzer), short press, chatter, long press (short buzzer)
        configure('0, 16'd3, '0);
        send_run(1'b0, 6);
        send_run(1'b1, 2);
        send_run(1'b0, 2);
        send_run(1'b1, 2);
        repeat (2) begin
            send_tick(1'b0);
            send_tick(1'b1);
        end
        configure('0, '0, 16'd2);
        send_run(1'b0, 2);
        send_run(1'b1, 5);

        run_phase(0, 0, 450);
        run_phase(71, 0, 450);
        run_phase(0, 71, 450);
        run_phase(15, 15, 450);

        // maximum debounce never sees a press
        send_idle_pct = 0;
        recv_stall_pct = 0;
        configure(CNT_MAX, 16'd10, 16'd5);
        send_run(1'b0, 40);
        send_run(1'b1, 40);

        s_valid <= 1'b0;
        guard = 0;
        while (board.expected_words.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (5) @(posedge aclk);
        board.check_drained();
        if (board.errors == 0)
            $display("debounced_short_long_press test passed");
        else
            $display("debounced_short_long_press test failed");
        $finish;
    end

endmodule

### filelist.f
design/dslp_pkg.sv
design/debounced_short_long_press.sv
tb/sv/debounced_short_long_press_test.sv
